// ===== rtl/core/checked_number_coercion_core_defines.svh =====
// Assertion macros for the checked number coercion core.
`ifndef CHECKED_NUMBER_COERCION_CORE_DEFINES_SVH
`define CHECKED_NUMBER_COERCION_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define NCC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ncc assertion failed");
`define NCC_ASSERT_ANY(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("ncc assertion failed");
`else
`define NCC_ASSERT(name, prop)
`define NCC_ASSERT_ANY(name, prop)
`endif
`endif

// ===== rtl/core/ncc_pkg.sv =====
`default_nettype none
package ncc_pkg;

  typedef enum logic [3:0] {
    TY_S16       = 4'd0,
    TY_U16       = 4'd1,
    TY_S32       = 4'd2,
    TY_U32       = 4'd3,
    TY_S64       = 4'd4,
    TY_U64       = 4'd5,
    TY_F32       = 4'd6,
    TY_F64       = 4'd7,
    TY_BOOL      = 4'd8,
    TY_TRUE      = 4'd9,
    TY_FALSE     = 4'd10,
    TY_CODE_TYPE = 4'd11,
    TY_CODE_ENUM = 4'd12,
    TY_CODE_KEYW = 4'd13,
    TY_OTHER     = 4'd14,
    TY_WILD      = 4'd15
  } ty_e;

  typedef struct packed {
    logic [3:0]  from_type;
    logic [3:0]  to_type;
    logic [63:0] raw_value;
    logic [3:0]  byte_count;
  } req_t;

  typedef struct packed {
    logic [3:0]  result_type;
    logic [63:0] result_value;
    logic [3:0]  result_bytes;
    logic        status;
  } rsp_t;

  typedef struct packed {
    logic        pass;
    logic        code_ok;
    logic        read_ok;
    logic        is_flt;
    req_t        req;
    logic [64:0] ival;
    logic [63:0] dbits;
  } dec_t;

  typedef struct packed {
    logic        pass;
    logic        code_ok;
    logic        read_ok;
    logic        is_flt;
    req_t        req;
    logic [64:0] ival;
    logic [63:0] imag;
    logic [5:0]  ilz;
    logic [63:0] dbits;
    logic [63:0] fmag;
    logic        fint_ok;
  } mid_t;

  typedef struct packed {
    logic        pass;
    logic        code_ok;
    logic        read_ok;
    req_t        req;
    logic [64:0] ival;
    logic        int_ok;
    logic [63:0] dnum;
  } num_t;

  localparam logic [62:0] F32_MAX_MAG = 63'h47EF_FFFF_E000_0000;

  function automatic logic [5:0] lzc64(input logic [63:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 6'(63 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc23(input logic [22:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 23; i++) begin
      if (v[i]) n = 5'(22 - i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ncc_decode.sv =====
`default_nettype none
module ncc_decode import ncc_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic dn_valid_o,
  input  wire  dn_ready_i,
  output dec_t dn_o
);

  dec_t        d_d, d_q;
  logic        v_q, en;
  logic        fs;
  logic [7:0]  fe;
  logic [22:0] fm, wsh;
  logic [4:0]  wlz;
  logic [10:0] wexp;
  logic [63:0] raw;
  logic [3:0]  cnt;
  ty_e         from_t, to_t;

  assign raw    = in_req_i.raw_value;
  assign cnt    = in_req_i.byte_count;
  assign from_t = ty_e'(in_req_i.from_type);
  assign to_t   = ty_e'(in_req_i.to_type);
  assign fs     = raw[31];
  assign fe     = raw[30:23];
  assign fm     = raw[22:0];
  assign wlz    = lzc23(fm);
  assign wsh    = fm << (wlz + 5'd1);
  assign wexp   = 11'd896 - 11'(wlz);

  always_comb begin
    d_d         = '0;
    d_d.req     = in_req_i;
    d_d.pass    = (to_t == TY_WILD) || (to_t == from_t);
    d_d.code_ok = (from_t inside {[TY_CODE_TYPE:TY_CODE_KEYW]}) &&
                  (to_t inside {[TY_CODE_TYPE:TY_CODE_KEYW]}) && (cnt == 4'd4);
    case (from_t)
      TY_S16: begin
        d_d.read_ok = cnt == 4'd2;
        d_d.ival    = {{49{raw[15]}}, raw[15:0]};
      end
      TY_U16: begin
        d_d.read_ok = cnt == 4'd2;
        d_d.ival    = {49'b0, raw[15:0]};
      end
      TY_S32: begin
        d_d.read_ok = cnt == 4'd4;
        d_d.ival    = {{33{raw[31]}}, raw[31:0]};
      end
      TY_U32: begin
        d_d.read_ok = cnt == 4'd4;
        d_d.ival    = {33'b0, raw[31:0]};
      end
      TY_S64: begin
        d_d.read_ok = cnt == 4'd8;
        d_d.ival    = {raw[63], raw};
      end
      TY_U64: begin
        d_d.read_ok = cnt == 4'd8;
        d_d.ival    = {1'b0, raw};
      end
      TY_F32: begin
        d_d.read_ok = cnt == 4'd4;
        d_d.is_flt  = 1'b1;
        if (fe == 8'hFF) begin
          d_d.dbits = (fm != '0) ? {fs, 11'h7FF, 1'b1, fm[21:0], 29'b0}
                                 : {fs, 11'h7FF, 52'b0};
        end else if (fe != 8'h00) begin
          d_d.dbits = {fs, 11'(fe) + 11'd896, fm, 29'b0};
        end else if (fm == '0) begin
          d_d.dbits = {fs, 63'b0};
        end else begin
          d_d.dbits = {fs, wexp, wsh, 29'b0};
        end
      end
      TY_F64: begin
        d_d.read_ok = cnt == 4'd8;
        d_d.is_flt  = 1'b1;
        d_d.dbits   = raw;
      end
      TY_BOOL: begin
        d_d.read_ok = cnt == 4'd1;
        d_d.ival    = {57'b0, raw[7:0]};
      end
      TY_TRUE: begin
        d_d.read_ok = 1'b1;
        d_d.ival    = 65'd1;
      end
      TY_FALSE: begin
        d_d.read_ok = 1'b1;
      end
      default: begin
        d_d.read_ok = 1'b0;
      end
    endcase
  end

  assign en         = !v_q || dn_ready_i;
  assign in_ready_o = en;
  assign dn_valid_o = v_q;
  assign dn_o       = d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      d_q <= d_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ncc_numcvt.sv =====
`default_nettype none
module ncc_numcvt import ncc_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  up_valid_i,
  output logic up_ready_o,
  input  dec_t up_i,
  output logic dn_valid_o,
  input  wire  dn_ready_i,
  output num_t dn_o
);

  mid_t         a_d, a_q;
  num_t         b_d, b_q;
  logic         va_q, vb_q, en_a, en_b;
  logic [64:0]  ineg;
  logic [10:0]  fe;
  logic [51:0]  fm;
  logic [5:0]   sh;
  logic [127:0] fext;
  logic         fzero;
  logic [63:0]  norm;
  logic [10:0]  iexp;
  logic         inc;
  logic [62:0]  ibody;
  logic [64:0]  fpos;
  logic [63:0]  dconv;

  assign ineg  = -up_i.ival;
  assign fe    = up_i.dbits[62:52];
  assign fm    = up_i.dbits[51:0];
  assign sh    = 6'(fe - 11'd1023);
  assign fext  = {1'b1, fm, 75'b0} >> (6'd63 - sh);
  assign fzero = (fe == '0) && (fm == '0);

  always_comb begin
    a_d         = '0;
    a_d.pass    = up_i.pass;
    a_d.code_ok = up_i.code_ok;
    a_d.read_ok = up_i.read_ok;
    a_d.is_flt  = up_i.is_flt;
    a_d.req     = up_i.req;
    a_d.ival    = up_i.ival;
    a_d.imag    = up_i.ival[64] ? ineg[63:0] : up_i.ival[63:0];
    a_d.ilz     = lzc64(a_d.imag);
    a_d.dbits   = up_i.dbits;
    a_d.fmag    = fzero ? 64'b0 : fext[127:64];
    a_d.fint_ok = fzero || ((fe >= 11'd1023) && (fe <= 11'd1086) && (fext[63:0] == '0));
  end

  assign norm  = a_q.imag << a_q.ilz;
  assign iexp  = 11'd1086 - 11'(a_q.ilz);
  assign inc   = norm[10] && ((norm[9:0] != '0) || norm[11]);
  assign ibody = {iexp, norm[62:11]} + 63'(inc);
  assign dconv = (a_q.imag == '0) ? 64'b0 : {a_q.ival[64], ibody};
  assign fpos  = {1'b0, a_q.fmag};

  always_comb begin
    b_d         = '0;
    b_d.pass    = a_q.pass;
    b_d.code_ok = a_q.code_ok;
    b_d.read_ok = a_q.read_ok;
    b_d.req     = a_q.req;
    if (a_q.is_flt) begin
      b_d.ival   = a_q.dbits[63] ? -fpos : fpos;
      b_d.int_ok = a_q.fint_ok;
      b_d.dnum   = a_q.dbits;
    end else begin
      b_d.ival   = a_q.ival;
      b_d.int_ok = 1'b1;
      b_d.dnum   = dconv;
    end
  end

  assign en_b       = !vb_q || dn_ready_i;
  assign en_a       = !va_q || en_b;
  assign up_ready_o = en_a;
  assign dn_valid_o = vb_q;
  assign dn_o       = b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= up_valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && up_valid_i) a_q <= a_d;
    if (en_b && va_q) b_q <= b_d;
  end

endmodule
`default_nettype wire

// ===== rtl/core/ncc_encode.sv =====
`default_nettype none
module ncc_encode import ncc_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  up_valid_i,
  output logic up_ready_o,
  input  num_t up_i,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output rsp_t out_rsp_o
);

  localparam logic signed [64:0] S16_LO = -65'sd32768;
  localparam logic signed [64:0] S16_HI = 65'sd32767;
  localparam logic signed [64:0] U16_HI = 65'sd65535;
  localparam logic signed [64:0] S32_LO = -65'sd2147483648;
  localparam logic signed [64:0] S32_HI = 65'sd2147483647;
  localparam logic signed [64:0] U32_HI = 65'sd4294967295;
  localparam logic signed [64:0] S64_LO = 65'sh1_8000_0000_0000_0000;
  localparam logic signed [64:0] S64_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] U64_HI = 65'sh0_FFFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] ZERO   = 65'sd0;
  localparam logic signed [64:0] ONE    = 65'sd1;

  rsp_t                r_d, r_q;
  logic                v_q, en;
  logic                s, finite, big, inc, int_tgt, in_rng;
  logic [10:0]         e;
  logic [51:0]         m;
  logic [52:0]         sig;
  logic [5:0]          sh;
  logic [7:0]          fexp;
  logic [116:0]        ext;
  logic [30:0]         fbody;
  logic [31:0]         f32;
  logic signed [64:0]  lo, hi, iv;
  logic [63:0]         mask;
  logic [3:0]          nb;
  ty_e                 to_t;

  assign s      = up_i.dnum[63];
  assign e      = up_i.dnum[62:52];
  assign m      = up_i.dnum[51:0];
  assign finite = e != 11'h7FF;
  assign big    = finite && (up_i.dnum[62:0] > F32_MAX_MAG);
  assign sig    = {e != '0, m};

  always_comb begin
    if (e >= 11'd897) begin
      sh   = 6'd29;
      fexp = 8'(e - 11'd896);
    end else if (e < 11'd863) begin
      sh   = 6'd63;
      fexp = 8'd0;
    end else begin
      sh   = 6'(11'd926 - e);
      fexp = 8'd0;
    end
  end

  assign ext   = {sig, 64'b0} >> sh;
  assign inc   = ext[63] && ((ext[62:0] != '0) || ext[64]);
  assign fbody = {fexp, ext[86:64]} + 31'(inc);

  always_comb begin
    if (!finite) begin
      f32 = (m != '0) ? {s, 8'hFF, 1'b1, m[50:29]} : {s, 8'hFF, 23'b0};
    end else begin
      f32 = {s, fbody};
    end
  end

  assign to_t = ty_e'(up_i.req.to_type);
  assign iv   = $signed(up_i.ival);

  always_comb begin
    int_tgt = 1'b1;
    lo      = ZERO;
    hi      = ONE;
    nb      = 4'd1;
    mask    = 64'hFF;
    case (to_t)
      TY_S16: begin
        lo = S16_LO; hi = S16_HI; nb = 4'd2; mask = 64'hFFFF;
      end
      TY_U16: begin
        hi = U16_HI; nb = 4'd2; mask = 64'hFFFF;
      end
      TY_S32: begin
        lo = S32_LO; hi = S32_HI; nb = 4'd4; mask = 64'hFFFF_FFFF;
      end
      TY_U32: begin
        hi = U32_HI; nb = 4'd4; mask = 64'hFFFF_FFFF;
      end
      TY_S64: begin
        lo = S64_LO; hi = S64_HI; nb = 4'd8; mask = '1;
      end
      TY_U64: begin
        hi = U64_HI; nb = 4'd8; mask = '1;
      end
      TY_BOOL: begin
        int_tgt = 1'b1;
      end
      default: begin
        int_tgt = 1'b0;
      end
    endcase
  end

  assign in_rng = up_i.int_ok && (iv >= lo) && (iv <= hi);

  always_comb begin
    r_d        = '0;
    r_d.status = 1'b1;
    if (up_i.pass) begin
      r_d.result_type  = up_i.req.from_type;
      r_d.result_value = up_i.req.raw_value;
      r_d.result_bytes = up_i.req.byte_count;
      r_d.status       = 1'b0;
    end else if (up_i.read_ok) begin
      if (int_tgt) begin
        if (in_rng) begin
          r_d.result_type  = up_i.req.to_type;
          r_d.result_value = up_i.ival[63:0] & mask;
          r_d.result_bytes = nb;
          r_d.status       = 1'b0;
        end
      end else if (to_t == TY_F64) begin
        r_d.result_type  = up_i.req.to_type;
        r_d.result_value = up_i.dnum;
        r_d.result_bytes = 4'd8;
        r_d.status       = 1'b0;
      end else if ((to_t == TY_F32) && !big) begin
        r_d.result_type  = up_i.req.to_type;
        r_d.result_value = {32'b0, f32};
        r_d.result_bytes = 4'd4;
        r_d.status       = 1'b0;
      end
    end else if (up_i.code_ok) begin
      r_d.result_type  = up_i.req.to_type;
      r_d.result_value = {32'b0, up_i.req.raw_value[31:0]};
      r_d.result_bytes = 4'd4;
      r_d.status       = 1'b0;
    end
  end

  assign en          = !v_q || out_ready_i;
  assign up_ready_o  = en;
  assign out_valid_o = v_q;
  assign out_rsp_o   = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && up_valid_i) begin
      r_q <= r_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/checked_number_coercion_core.sv =====
// Checked number coercion core.
// Input channel: in_valid_i / in_ready_o with one request in in_req_i (source
// type, target type, up to 8 little-endian data bytes, byte count).
// Output channel: out_valid_o / out_ready_i with one response in out_rsp_o
// (result type, result bytes, result byte count, status; 1 = coercion failed,
// all other fields zero).
// Every request produces exactly one response, in request order.
// A request passes through four register stages (decode, int/float unpack,
// normalize and round to float64, range check and float32 rounding) from
// accept to response valid. Each stage holds its own valid bit.
// Throughput: one request per cycle while out_ready_i is high.
// Stall: when out_ready_i is low the response holds; earlier stages keep
// filling bubbles, and in_ready_o drops only once all stages hold a request.
// Reset: asynchronous, active low, clears all valid bits; the pipeline is
// empty and ready right after reset. There is no configuration.
`default_nettype none
`include "checked_number_coercion_core_defines.svh"
module checked_number_coercion_core import ncc_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output rsp_t out_rsp_o
);

  dec_t dec;
  num_t num;
  logic dec_valid, dec_ready, num_valid, num_ready;

  ncc_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .dn_valid_o (dec_valid),
    .dn_ready_i (dec_ready),
    .dn_o       (dec)
  );

  ncc_numcvt u_numcvt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (dec_valid),
    .up_ready_o (dec_ready),
    .up_i       (dec),
    .dn_valid_o (num_valid),
    .dn_ready_i (num_ready),
    .dn_o       (num)
  );

  ncc_encode u_encode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .up_valid_i  (num_valid),
    .up_ready_o  (num_ready),
    .up_i        (num),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  `NCC_ASSERT(a_fail_zero, out_valid_o && out_rsp_o.status |-> out_rsp_o.result_type == 4'd0 && out_rsp_o.result_value == 64'd0 && out_rsp_o.result_bytes == 4'd0)
  `NCC_ASSERT(a_no_block, out_ready_i |-> in_ready_o)
  `NCC_ASSERT(a_drain, !out_valid_o && !num_valid |-> num_ready)
  `NCC_ASSERT_ANY(a_rst_idle, !rst_ni |=> !out_valid_o)

endmodule
`default_nettype wire
